[rtl/psmi_pkg.sv]
// Package for the packed symmetric matrix indexer.
// Holds widths, register indexes and the item, result and configuration view types.
// Depends on nothing; every other file in rtl imports it.
package psmi_pkg;

    localparam int MAX_ITEMS     = 4096;
    localparam int COORD_W       = 12;
    localparam int END_W         = 13;
    localparam int VALUE_W       = 32;
    localparam int SLOT_W        = 24;
    localparam int SIZE_W        = 25;
    localparam int PROD_W        = 27;
    localparam int SUM_W         = 28;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 13;
    localparam int SETTLE_CYCLES = 3;

    localparam logic [END_W-1:0]  MAX_END  = END_W'(MAX_ITEMS);
    localparam logic [PROD_W-1:0] SLOT_MAX = PROD_W'((2 ** SLOT_W) - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COL_START = 3'd0,
        CFG_COL_END   = 3'd1,
        CFG_ROW_START = 3'd2,
        CFG_ROW_END   = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] col_index;
        logic [COORD_W-1:0] row_index;
        logic [VALUE_W-1:0] pair_value;
    } t_item;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_index;
        logic [VALUE_W-1:0] write_value;
        logic               mirror_valid;
        logic [SLOT_W-1:0]  mirror_slot;
        logic               index_error;
        logic               is_triangular;
        logic [SIZE_W-1:0]  storage_size;
        logic [SIZE_W-1:0]  unique_count;
    } t_result;

    typedef struct packed {
        logic [COORD_W-1:0] cs;
        logic [END_W-1:0]   ce;
        logic [COORD_W-1:0] rs;
        logic [END_W-1:0]   re;
        logic [END_W-1:0]   w;
        logic [END_W-1:0]   h;
        logic               triangular;
    } t_range;

    typedef struct packed {
        t_range            rng;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] uniq;
        logic              settling;
    } t_cfg_view;

endpackage

[rtl/psmi_cfg.sv]
// Configuration registers and the derived range, size and unique-count pipeline.
// The derived values pass through the range, product and size registers after a write; depends on psmi_pkg.
module psmi_cfg import psmi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_cfg_view             o_view
);

    logic [COORD_W-1:0] r_col_start;
    logic [END_W-1:0]   r_col_end;
    logic [COORD_W-1:0] r_row_start;
    logic [END_W-1:0]   r_row_end;
    logic [1:0]         r_settle;

    t_range             n_rng, r_rng;
    logic               n_overlap, r_overlap;
    logic [END_W-1:0]   n_bt, n_bb, n_bl, n_br, n_a;
    logic [END_W-1:0]   r_bt, r_bb, r_bl, r_br, r_a;

    logic [PROD_W-1:0]  r_wh, r_ww, r_wbt, r_abl, r_aa, r_abr, r_wbb;
    logic [SIZE_W-1:0]  n_size, r_size, n_uniq, r_uniq;
    logic [SUM_W-1:0]   sum_uniq;
    logic               col_bad, row_bad;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_start <= '0;
            r_col_end   <= MAX_END;
            r_row_start <= '0;
            r_row_end   <= MAX_END;
            r_settle    <= 2'(SETTLE_CYCLES);
        end else begin
            if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_COL_START: r_col_start <= i_cfg_data[COORD_W-1:0];
                    CFG_COL_END:   r_col_end   <= i_cfg_data[END_W-1:0];
                    CFG_ROW_START: r_row_start <= i_cfg_data[COORD_W-1:0];
                    CFG_ROW_END:   r_row_end   <= i_cfg_data[END_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        col_bad = ({1'b0, r_col_start} >= r_col_end) || (r_col_end > MAX_END);
        row_bad = ({1'b0, r_row_start} >= r_row_end) || (r_row_end > MAX_END);
        n_rng.cs  = col_bad ? '0 : r_col_start;
        n_rng.ce  = col_bad ? MAX_END : r_col_end;
        n_rng.rs  = row_bad ? '0 : r_row_start;
        n_rng.re  = row_bad ? MAX_END : r_row_end;
        n_rng.w   = n_rng.ce - {1'b0, n_rng.cs};
        n_rng.h   = n_rng.re - {1'b0, n_rng.rs};
        n_rng.triangular = (n_rng.cs == n_rng.rs) && (n_rng.ce == n_rng.re);
        n_overlap = !((n_rng.re <= {1'b0, n_rng.cs}) || ({1'b0, n_rng.rs} >= n_rng.ce));
        n_bt = (n_rng.cs > n_rng.rs) ? END_W'(n_rng.cs - n_rng.rs) : '0;
        n_bl = (n_rng.rs > n_rng.cs) ? END_W'(n_rng.rs - n_rng.cs) : '0;
        n_bb = (n_rng.re > n_rng.ce) ? (n_rng.re - n_rng.ce) : '0;
        n_br = (n_rng.ce > n_rng.re) ? (n_rng.ce - n_rng.re) : '0;
        n_a  = n_rng.h - n_bt - n_bb;
    end

    always_ff @(posedge i_clk) begin
        r_rng     <= n_rng;
        r_overlap <= n_overlap;
        r_bt      <= n_bt;
        r_bb      <= n_bb;
        r_bl      <= n_bl;
        r_br      <= n_br;
        r_a       <= n_a;
    end

    always_ff @(posedge i_clk) begin
        r_wh  <= PROD_W'(r_rng.w) * PROD_W'(r_rng.h);
        r_ww  <= PROD_W'(r_rng.w) * (PROD_W'(r_rng.w) + PROD_W'(1));
        r_wbt <= PROD_W'(r_rng.w) * PROD_W'(r_bt);
        r_abl <= PROD_W'(r_a) * PROD_W'(r_bl);
        r_aa  <= PROD_W'(r_a) * (PROD_W'(r_a) + PROD_W'(1));
        r_abr <= PROD_W'(r_a) * PROD_W'(r_br);
        r_wbb <= PROD_W'(r_rng.w) * PROD_W'(r_bb);
    end

    always_comb begin
        sum_uniq = SUM_W'(r_wbt) + SUM_W'(r_abl) + SUM_W'(r_aa >> 1)
                 + SUM_W'(r_abr) + SUM_W'(r_wbb);
        n_size = r_rng.triangular ? SIZE_W'(r_ww >> 1) : SIZE_W'(r_wh);
        n_uniq = r_overlap ? sum_uniq[SIZE_W-1:0] : SIZE_W'(r_wh);
    end

    always_ff @(posedge i_clk) begin
        r_size <= n_size;
        r_uniq <= n_uniq;
    end

    assign o_view.rng      = r_rng;
    assign o_view.size     = r_size;
    assign o_view.uniq     = r_uniq;
    assign o_view.settling = (r_settle != 2'd0);

endmodule

[rtl/psmi_core.sv]
// Slot pipeline: input register, range checks, products, then the result register.
// Reads the range and size view from psmi_cfg; depends on psmi_pkg.
module psmi_core import psmi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_item     i_item,
    input  t_cfg_view i_view,
    output logic      o_result_valid,
    output t_result   o_result
);

    logic               r_v0, r_v1, r_v2, r_v3;
    t_item              r_in;

    logic               n_err1, n_mr1;
    logic [COORD_W-1:0] n_co1, n_ro1, n_mco1, n_mro1, n_i1, n_d1;
    logic               r_err1, r_mr1;
    logic [COORD_W-1:0] r_co1, r_ro1, r_mco1, r_mro1, r_i1, r_d1;
    logic [VALUE_W-1:0] r_val1, r_val2;

    logic               r_err2, r_mr2;
    logic [COORD_W-1:0] r_co2, r_mco2, r_d2;
    logic [PROD_W-1:0]  r_iw2, r_ii2, r_rw2, r_mw2;

    logic [PROD_W-1:0]  slot, mslot, size_ext;
    logic               mval, err;
    t_result            n_res, r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= i_accept;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_in <= i_item;
        end
    end

    always_comb begin
        n_err1 = !((r_in.col_index >= i_view.rng.cs)
                && ({1'b0, r_in.col_index} < i_view.rng.ce)
                && (r_in.row_index >= i_view.rng.rs)
                && ({1'b0, r_in.row_index} < i_view.rng.re));
        n_mr1  = (r_in.row_index >= i_view.rng.cs)
              && ({1'b0, r_in.row_index} < i_view.rng.ce)
              && (r_in.col_index >= i_view.rng.rs)
              && ({1'b0, r_in.col_index} < i_view.rng.re);
        n_co1  = r_in.col_index - i_view.rng.cs;
        n_ro1  = r_in.row_index - i_view.rng.rs;
        n_mco1 = r_in.row_index - i_view.rng.cs;
        n_mro1 = r_in.col_index - i_view.rng.rs;
        n_i1   = (n_co1 > n_ro1) ? n_ro1 : n_co1;
        n_d1   = (n_co1 > n_ro1) ? (n_co1 - n_ro1) : (n_ro1 - n_co1);
    end

    always_ff @(posedge i_clk) begin
        r_err1 <= n_err1;
        r_mr1  <= n_mr1;
        r_co1  <= n_co1;
        r_ro1  <= n_ro1;
        r_mco1 <= n_mco1;
        r_mro1 <= n_mro1;
        r_i1   <= n_i1;
        r_d1   <= n_d1;
        r_val1 <= r_in.pair_value;
    end

    always_ff @(posedge i_clk) begin
        r_iw2  <= PROD_W'(r_i1) * PROD_W'(i_view.rng.w);
        r_ii2  <= PROD_W'(r_i1) * PROD_W'(r_i1 - COORD_W'(1));
        r_rw2  <= PROD_W'(r_ro1) * PROD_W'(i_view.rng.w);
        r_mw2  <= PROD_W'(r_mro1) * PROD_W'(i_view.rng.w);
        r_err2 <= r_err1;
        r_mr2  <= r_mr1;
        r_co2  <= r_co1;
        r_mco2 <= r_mco1;
        r_d2   <= r_d1;
        r_val2 <= r_val1;
    end

    always_comb begin
        size_ext = PROD_W'(i_view.size);
        slot  = i_view.rng.triangular ? (PROD_W'(r_d2) + r_iw2 - (r_ii2 >> 1))
                                      : (PROD_W'(r_co2) + r_rw2);
        mslot = PROD_W'(r_mco2) + r_mw2;
        mval  = !i_view.rng.triangular && r_mr2 && !r_err2;
        err   = r_err2 || (slot >= size_ext) || (slot > SLOT_MAX)
             || (mval && ((mslot >= size_ext) || (mslot > SLOT_MAX)));
        n_res.slot_index    = err ? '0 : slot[SLOT_W-1:0];
        n_res.write_value   = r_val2;
        n_res.mirror_valid  = mval && !err;
        n_res.mirror_slot   = (mval && !err) ? mslot[SLOT_W-1:0] : '0;
        n_res.index_error   = err;
        n_res.is_triangular = i_view.rng.triangular;
        n_res.storage_size  = i_view.size;
        n_res.unique_count  = i_view.uniq;
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_result_valid = r_v3;
    assign o_result       = r_res;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> ##4 r_v3)
        else $error("An accepted item did not produce a result four cycles later.");

    a_err_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_res.index_error) |->
        (r_res.slot_index == '0 && !r_res.mirror_valid && r_res.mirror_slot == '0))
        else $error("A flagged result carries a non-zero slot or mirror.");

    a_mirror_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_res.mirror_valid) |-> !r_res.is_triangular)
        else $error("A mirror slot was reported for the triangular layout.");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_res.index_error) |-> ({1'b0, r_res.slot_index} < r_res.storage_size))
        else $error("An unflagged slot is not below the storage size.");

endmodule

[rtl/packed_symmetric_matrix_indexer_top.sv]
// Top level of the packed symmetric matrix indexer.
// Instantiates psmi_cfg and psmi_core; depends on psmi_pkg.
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+-------------------------------
//   item     | in        | i_start high, o_busy low    | i_item (t_item)
//   result   | out       | o_result_valid, one cycle   | o_result (t_result)
//   config   | in        | i_cfg_valid and o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item is accepted in every cycle while o_busy is low; each result passes through
// the input, check, product and result registers of the slot pipeline.
// Derived range sizes settle through the range, product and size registers after a configuration write.
// Reset is synchronous and active low; o_busy is held high by the settle counter after it.
// The receiver cannot stall, so o_busy is never raised by traffic.
module packed_symmetric_matrix_indexer_top import psmi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_item                 i_item,
    output logic                  o_result_valid,
    output t_result               o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg_view view;
    logic      accept;

    psmi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_view      (view)
    );

    assign o_busy = view.settling;
    assign accept = i_start && !o_busy;

    psmi_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_item         (i_item),
        .i_view         (view),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule
